// ----- design/bfts_pkg.sv -----
// Shared types and constants for the brute-force tour search block.
package bfts_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_TOUR   = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_NUM_CITIES = 1'b0;
    localparam logic [0:0] REG_PERM_COUNT = 1'b1;

    // Port widths fixed by the interface
    localparam int CITY_W   = 3;
    localparam int COST_W   = 19;
    localparam int WDATA_W  = 16;
    localparam int NCITY_W  = 4;
    localparam int PCOUNT_W = 16;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Controls from the sequencer to the edge accumulator
    typedef struct packed {
        logic load;   // write one weight table entry
        logic rd;     // look up one edge weight
        logic clear;  // start a new tour sum
        logic add;    // add the looked-up weight, saturating
    } acc_ctrl_t;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR,
        S_C_RD0,
        S_C_FIRST,
        S_C_RD,
        S_C_WADDR,
        S_C_ACC,
        S_C_CLOSE,
        S_CMP,
        S_BC_RD,
        S_BC_WR,
        S_NEXT,
        S_NP_RDL,
        S_NP_LASTQ,
        S_NP_RDM,
        S_NP_CMPM,
        S_NP_RDK,
        S_NP_CMPK,
        S_NP_SW1,
        S_NP_SW2,
        S_RV_CHK,
        S_RV_RDP,
        S_RV_RDQ,
        S_RV_WP,
        S_RV_WQ,
        S_OUT_RD,
        S_OUT
    } state_t;

endpackage

// ----- design/bfts_edge_acc.sv -----
// Weight table memory with registered lookup and saturating tour-cost accumulator.
module bfts_edge_acc #(
    parameter int MAX_CITIES  = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            aclk,
    input  bfts_pkg::acc_ctrl_t             ctrl,
    input  logic [bfts_pkg::CITY_W-1:0]     wr_row,
    input  logic [bfts_pkg::CITY_W-1:0]     wr_col,
    input  logic [bfts_pkg::WDATA_W-1:0]    wr_data,
    input  logic [bfts_pkg::CITY_W-1:0]     rd_from,
    input  logic [bfts_pkg::CITY_W-1:0]     rd_to,
    output logic [bfts_pkg::COST_W-1:0]     sum
);

    localparam int WW    = (WEIGHT_BITS < bfts_pkg::WDATA_W) ? WEIGHT_BITS : bfts_pkg::WDATA_W;
    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW    = $clog2(DEPTH);

    logic [WW-1:0]                mem [DEPTH];
    logic [WW-1:0]                rd_q_reg;
    logic [bfts_pkg::COST_W-1:0]  sum_reg;
    logic [bfts_pkg::COST_W-1:0]  sum_next;
    logic [bfts_pkg::COST_W:0]    sum_wide;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic                         wr_ok;
    logic                         rd_ok;

    // Flatten row and column into a table address
    assign wr_addr = AW'(AW'(wr_row) * AW'(MAX_CITIES) + AW'(wr_col));
    assign rd_addr = AW'(AW'(rd_from) * AW'(MAX_CITIES) + AW'(rd_to));
    assign wr_ok   = (int'(wr_row) < MAX_CITIES) && (int'(wr_col) < MAX_CITIES);
    assign rd_ok   = (int'(rd_from) < MAX_CITIES) && (int'(rd_to) < MAX_CITIES);

    // Write weights, look up one edge; an edge touching an unknown city weighs zero
    always_ff @(posedge aclk) begin
        if (ctrl.load && wr_ok) begin
            mem[wr_addr] <= wr_data[WW-1:0];
        end
        if (ctrl.rd) begin
            if (rd_ok) begin
                rd_q_reg <= mem[rd_addr];
            end else begin
                rd_q_reg <= '0;
            end
        end
    end

    // Saturating add of the looked-up weight
    always_comb begin
        sum_wide = {1'b0, sum_reg} + (bfts_pkg::COST_W + 1)'(rd_q_reg);
        if (sum_wide > (bfts_pkg::COST_W + 1)'(bfts_pkg::COST_MAX)) begin
            sum_next = bfts_pkg::COST_MAX;
        end else begin
            sum_next = sum_wide[bfts_pkg::COST_W-1:0];
        end
    end

    // Hold the running tour sum
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            sum_reg <= '0;
        end else if (ctrl.add) begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ----- design/brute_force_tour_search.sv -----
// Top level: loads weights and a start tour, then searches tours in lexicographic order.
//
//  channel  dir  handshake              payload
//  s_       in   s_valid / s_ready      s_cmd s_row s_col s_weight s_position s_city
//  m_       out  m_valid / m_ready      m_min_cost m_tour_position m_tour_city m_last
//  cfg_     in   cfg_wr_en              cfg_index cfg_wr_data
//
// Load beats are taken while idle. A run beat copies the start tour, then for each tour
// scores it, copies it to the best tour when it improves, and steps to the next
// permutation; the single read port of the working tour memory and the shared edge
// accumulator serialise these steps. Each result beat is read from the best tour memory
// before it is offered, so results do not leave back to back. s_ready is high only between runs.
// aresetn is synchronous and clears the sequencer and configuration; memories hold.
module brute_force_tour_search #(
    parameter int MAX_CITIES  = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_index,
    input  logic [bfts_pkg::PCOUNT_W-1:0]     cfg_wr_data,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic [2:0]                        s_row,
    input  logic [2:0]                        s_col,
    input  logic [15:0]                       s_weight,
    input  logic [2:0]                        s_position,
    input  logic [2:0]                        s_city,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [18:0]                       m_min_cost,
    output logic [2:0]                        m_tour_position,
    output logic [2:0]                        m_tour_city,
    output logic                              m_last
);

    localparam int PW = $clog2(MAX_CITIES);
    localparam int CW = $clog2(MAX_CITIES + 1);
    localparam int CTW = bfts_pkg::CITY_W;

    bfts_pkg::state_t state_reg, state_next;

    logic [bfts_pkg::NCITY_W-1:0]  num_cities_reg;
    logic [bfts_pkg::PCOUNT_W-1:0] perm_count_reg;

    logic [CW-1:0]   n_reg, n_next, n_clamp;
    logic [PW-1:0]   n_m1;
    logic [PW-1:0]   idx_reg, idx_next;
    logic [PW-1:0]   m_reg, m_next;
    logic [PW-1:0]   k_reg, k_next;
    logic [CTW-1:0]  hold_reg, hold_next;
    logic [CTW-1:0]  piv_reg, piv_next;
    logic [CTW-1:0]  first_reg, first_next;
    logic [CTW-1:0]  prev_reg, prev_next;
    logic            closing_reg, closing_next;
    logic            first_eval_reg, first_eval_next;
    logic [bfts_pkg::PCOUNT_W-1:0] total_reg, total_next;
    logic [bfts_pkg::PCOUNT_W-1:0] perm_idx_reg, perm_idx_next;
    logic [bfts_pkg::COST_W-1:0]   best_cost_reg, best_cost_next;

    // tour memories
    logic [CTW-1:0] cur_mem  [MAX_CITIES];
    logic [CTW-1:0] work_mem [MAX_CITIES];
    logic [CTW-1:0] best_mem [MAX_CITIES];
    logic [CTW-1:0] cur_q_reg, work_q_reg, best_q_reg;

    logic           cur_wr_en, cur_rd_en;
    logic           work_wr_en, work_rd_en;
    logic           best_wr_en, best_rd_en;
    logic [PW-1:0]  cur_wr_addr;
    logic [PW-1:0]  work_wr_addr, work_rd_addr;
    logic [CTW-1:0] work_wr_data, best_wr_data;

    bfts_pkg::acc_ctrl_t     acc_ctrl;
    logic [CTW-1:0]          acc_from, acc_to;
    logic [bfts_pkg::COST_W-1:0] tour_sum;

    logic s_beat;
    logic m_beat;
    logic run_beat;
    logic idx_last;
    logic improve;

    assign s_beat   = s_valid && s_ready;
    assign m_beat   = m_valid && m_ready;
    assign run_beat = s_beat && (s_cmd == bfts_pkg::CMD_RUN);
    assign n_m1     = PW'(n_reg - CW'(1));
    assign idx_last = (idx_reg == n_m1);
    assign improve  = first_eval_reg || (tour_sum < best_cost_reg);

    // Clamp the configured city count into the supported range
    always_comb begin
        if (num_cities_reg < bfts_pkg::NCITY_W'(2)) begin
            n_clamp = CW'(2);
        end else if (int'(num_cities_reg) > MAX_CITIES) begin
            n_clamp = CW'(MAX_CITIES);
        end else begin
            n_clamp = CW'(num_cities_reg);
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cities_reg <= bfts_pkg::NCITY_W'(8);
            perm_count_reg <= bfts_pkg::PCOUNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bfts_pkg::REG_NUM_CITIES: num_cities_reg <= cfg_wr_data[bfts_pkg::NCITY_W-1:0];
                bfts_pkg::REG_PERM_COUNT: perm_count_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfts_pkg::S_IDLE:     if (run_beat) state_next = bfts_pkg::S_COPY_RD;
            bfts_pkg::S_COPY_RD:  state_next = bfts_pkg::S_COPY_WR;
            bfts_pkg::S_COPY_WR:  state_next = idx_last ? bfts_pkg::S_C_RD0 : bfts_pkg::S_COPY_RD;
            bfts_pkg::S_C_RD0:    state_next = bfts_pkg::S_C_FIRST;
            bfts_pkg::S_C_FIRST:  state_next = bfts_pkg::S_C_RD;
            bfts_pkg::S_C_RD:     state_next = bfts_pkg::S_C_WADDR;
            bfts_pkg::S_C_WADDR:  state_next = bfts_pkg::S_C_ACC;
            bfts_pkg::S_C_ACC: begin
                if (closing_reg) state_next = bfts_pkg::S_CMP;
                else if (idx_last) state_next = bfts_pkg::S_C_CLOSE;
                else state_next = bfts_pkg::S_C_RD;
            end
            bfts_pkg::S_C_CLOSE:  state_next = bfts_pkg::S_C_ACC;
            bfts_pkg::S_CMP: begin
                if (improve && !first_eval_reg) state_next = bfts_pkg::S_BC_RD;
                else state_next = bfts_pkg::S_NEXT;
            end
            bfts_pkg::S_BC_RD:    state_next = bfts_pkg::S_BC_WR;
            bfts_pkg::S_BC_WR:    state_next = idx_last ? bfts_pkg::S_NEXT : bfts_pkg::S_BC_RD;
            bfts_pkg::S_NEXT: begin
                if (perm_idx_reg >= total_reg) state_next = bfts_pkg::S_OUT_RD;
                else state_next = bfts_pkg::S_NP_RDL;
            end
            bfts_pkg::S_NP_RDL:   state_next = bfts_pkg::S_NP_LASTQ;
            bfts_pkg::S_NP_LASTQ: state_next = bfts_pkg::S_NP_RDM;
            bfts_pkg::S_NP_RDM:   state_next = bfts_pkg::S_NP_CMPM;
            bfts_pkg::S_NP_CMPM: begin
                if (work_q_reg >= hold_reg) begin
                    state_next = (m_reg == '0) ? bfts_pkg::S_OUT_RD : bfts_pkg::S_NP_RDM;
                end else begin
                    state_next = bfts_pkg::S_NP_RDK;
                end
            end
            bfts_pkg::S_NP_RDK:   state_next = bfts_pkg::S_NP_CMPK;
            bfts_pkg::S_NP_CMPK: begin
                if (work_q_reg <= piv_reg) state_next = bfts_pkg::S_NP_RDK;
                else state_next = bfts_pkg::S_NP_SW1;
            end
            bfts_pkg::S_NP_SW1:   state_next = bfts_pkg::S_NP_SW2;
            bfts_pkg::S_NP_SW2:   state_next = bfts_pkg::S_RV_CHK;
            bfts_pkg::S_RV_CHK: begin
                if (idx_reg < k_reg) state_next = bfts_pkg::S_RV_RDP;
                else state_next = bfts_pkg::S_C_RD0;
            end
            bfts_pkg::S_RV_RDP:   state_next = bfts_pkg::S_RV_RDQ;
            bfts_pkg::S_RV_RDQ:   state_next = bfts_pkg::S_RV_WP;
            bfts_pkg::S_RV_WP:    state_next = bfts_pkg::S_RV_WQ;
            bfts_pkg::S_RV_WQ:    state_next = bfts_pkg::S_RV_CHK;
            bfts_pkg::S_OUT_RD:   state_next = bfts_pkg::S_OUT;
            bfts_pkg::S_OUT: begin
                if (m_ready) state_next = idx_last ? bfts_pkg::S_IDLE : bfts_pkg::S_OUT_RD;
            end
            default:              state_next = bfts_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: counters, scratch registers, memory and accumulator controls
    always_comb begin
        n_next          = n_reg;
        idx_next        = idx_reg;
        m_next          = m_reg;
        k_next          = k_reg;
        hold_next       = hold_reg;
        piv_next        = piv_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;
        closing_next    = closing_reg;
        first_eval_next = first_eval_reg;
        total_next      = total_reg;
        perm_idx_next   = perm_idx_reg;
        best_cost_next  = best_cost_reg;

        cur_wr_en    = 1'b0;
        cur_wr_addr  = PW'(s_position);
        cur_rd_en    = 1'b0;
        work_wr_en   = 1'b0;
        work_wr_addr = idx_reg;
        work_wr_data = cur_q_reg;
        work_rd_en   = 1'b0;
        work_rd_addr = idx_reg;
        best_wr_en   = 1'b0;
        best_wr_data = cur_q_reg;
        best_rd_en   = 1'b0;
        acc_ctrl     = '0;
        acc_from     = prev_reg;
        acc_to       = work_q_reg;

        unique case (state_reg)
            bfts_pkg::S_IDLE: begin
                if (s_beat) begin
                    unique case (s_cmd)
                        bfts_pkg::CMD_WEIGHT: acc_ctrl.load = 1'b1;
                        bfts_pkg::CMD_TOUR:   cur_wr_en = (int'(s_position) < MAX_CITIES);
                        bfts_pkg::CMD_RUN: begin
                            n_next          = n_clamp;
                            idx_next        = '0;
                            first_eval_next = 1'b1;
                            perm_idx_next   = bfts_pkg::PCOUNT_W'(1);
                            total_next      = (perm_count_reg == '0) ?
                                              bfts_pkg::PCOUNT_W'(1) : perm_count_reg;
                        end
                        default: ;
                    endcase
                end
            end
            bfts_pkg::S_COPY_RD: cur_rd_en = 1'b1;
            bfts_pkg::S_COPY_WR: begin
                work_wr_en = 1'b1;
                best_wr_en = 1'b1;
                if (!idx_last) idx_next = idx_reg + PW'(1);
            end
            // score the working tour as a closed cycle
            bfts_pkg::S_C_RD0: begin
                work_rd_en   = 1'b1;
                work_rd_addr = '0;
                idx_next     = PW'(1);
                closing_next = 1'b0;
            end
            bfts_pkg::S_C_FIRST: begin
                first_next     = work_q_reg;
                prev_next      = work_q_reg;
                acc_ctrl.clear = 1'b1;
            end
            bfts_pkg::S_C_RD: work_rd_en = 1'b1;
            bfts_pkg::S_C_WADDR: begin
                acc_ctrl.rd = 1'b1;
                prev_next   = work_q_reg;
            end
            bfts_pkg::S_C_ACC: begin
                acc_ctrl.add = 1'b1;
                if (!closing_reg && !idx_last) idx_next = idx_reg + PW'(1);
            end
            bfts_pkg::S_C_CLOSE: begin
                acc_ctrl.rd  = 1'b1;
                acc_to       = first_reg;
                closing_next = 1'b1;
            end
            // keep the least cost; copy the tour only when it improves
            bfts_pkg::S_CMP: begin
                if (improve) best_cost_next = tour_sum;
                first_eval_next = 1'b0;
                idx_next        = '0;
            end
            bfts_pkg::S_BC_RD: work_rd_en = 1'b1;
            bfts_pkg::S_BC_WR: begin
                best_wr_en   = 1'b1;
                best_wr_data = work_q_reg;
                if (!idx_last) idx_next = idx_reg + PW'(1);
            end
            bfts_pkg::S_NEXT: idx_next = '0;
            // next permutation: find the pivot from the right
            bfts_pkg::S_NP_RDL: begin
                work_rd_en   = 1'b1;
                work_rd_addr = n_m1;
                m_next       = PW'(n_reg - CW'(2));
            end
            bfts_pkg::S_NP_LASTQ: hold_next = work_q_reg;
            bfts_pkg::S_NP_RDM: begin
                work_rd_en   = 1'b1;
                work_rd_addr = m_reg;
            end
            bfts_pkg::S_NP_CMPM: begin
                if (work_q_reg >= hold_reg) begin
                    hold_next = work_q_reg;
                    if (m_reg != '0) m_next = m_reg - PW'(1);
                    idx_next = '0;
                end else begin
                    piv_next = work_q_reg;
                    k_next   = n_m1;
                end
            end
            // find the rightmost entry above the pivot
            bfts_pkg::S_NP_RDK: begin
                work_rd_en   = 1'b1;
                work_rd_addr = k_reg;
            end
            bfts_pkg::S_NP_CMPK: begin
                if (work_q_reg <= piv_reg) k_next = k_reg - PW'(1);
                else hold_next = work_q_reg;
            end
            // swap pivot and successor
            bfts_pkg::S_NP_SW1: begin
                work_wr_en   = 1'b1;
                work_wr_addr = m_reg;
                work_wr_data = hold_reg;
            end
            bfts_pkg::S_NP_SW2: begin
                work_wr_en   = 1'b1;
                work_wr_addr = k_reg;
                work_wr_data = piv_reg;
                idx_next     = m_reg + PW'(1);
                k_next       = n_m1;
            end
            // reverse the tail, one pair per pass
            bfts_pkg::S_RV_CHK: begin
                if (idx_reg >= k_reg) perm_idx_next = perm_idx_reg + bfts_pkg::PCOUNT_W'(1);
            end
            bfts_pkg::S_RV_RDP: work_rd_en = 1'b1;
            bfts_pkg::S_RV_RDQ: begin
                hold_next    = work_q_reg;
                work_rd_en   = 1'b1;
                work_rd_addr = k_reg;
            end
            bfts_pkg::S_RV_WP: begin
                work_wr_en   = 1'b1;
                work_wr_data = work_q_reg;
            end
            bfts_pkg::S_RV_WQ: begin
                work_wr_en   = 1'b1;
                work_wr_addr = k_reg;
                work_wr_data = hold_reg;
                idx_next     = idx_reg + PW'(1);
                k_next       = k_reg - PW'(1);
            end
            // emit the best tour, one position per beat
            bfts_pkg::S_OUT_RD: best_rd_en = 1'b1;
            bfts_pkg::S_OUT: begin
                if (m_ready && !idx_last) idx_next = idx_reg + PW'(1);
            end
            default: ;
        endcase
    end

    // Control and scratch registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bfts_pkg::S_IDLE;
            best_cost_reg  <= '0;
            perm_idx_reg   <= '0;
            first_eval_reg <= 1'b0;
            closing_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            best_cost_reg  <= best_cost_next;
            perm_idx_reg   <= perm_idx_next;
            first_eval_reg <= first_eval_next;
            closing_reg    <= closing_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        m_reg     <= m_next;
        k_reg     <= k_next;
        hold_reg  <= hold_next;
        piv_reg   <= piv_next;
        first_reg <= first_next;
        prev_reg  <= prev_next;
        total_reg <= total_next;
    end

    // Tour memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (cur_wr_en) cur_mem[cur_wr_addr] <= s_city;
        if (cur_rd_en) cur_q_reg <= cur_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (work_wr_en) work_mem[work_wr_addr] <= work_wr_data;
        if (work_rd_en) work_q_reg <= work_mem[work_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (best_wr_en) best_mem[idx_reg] <= best_wr_data;
        if (best_rd_en) best_q_reg <= best_mem[idx_reg];
    end

    // Weight table and tour cost accumulator
    bfts_edge_acc #(
        .MAX_CITIES  (MAX_CITIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_edge_acc (
        .aclk    (aclk),
        .ctrl    (acc_ctrl),
        .wr_row  (s_row),
        .wr_col  (s_col),
        .wr_data (s_weight),
        .rd_from (acc_from),
        .rd_to   (acc_to),
        .sum     (tour_sum)
    );

    // Handshake and result fields
    assign s_ready         = (state_reg == bfts_pkg::S_IDLE);
    assign m_valid         = (state_reg == bfts_pkg::S_OUT);
    assign m_min_cost      = best_cost_reg;
    assign m_tour_position = 3'(idx_reg);
    assign m_tour_city     = best_q_reg;
    assign m_last          = idx_last;

    // Input and result sides never open together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels both open");

    // A run beat closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_beat |=> !s_ready)
        else $error("input side still open after run beat");

    // The final result beat reopens the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && m_last) |=> (s_ready && !m_valid))
        else $error("block not idle after final result beat");

    // Position resets to zero on the first result of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && ($past(state_reg, 2) != bfts_pkg::S_OUT) |-> m_tour_position == 3'd0)
        else $error("first result beat not at position zero");

endmodule
